// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the index of coincidence block
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LIC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LIC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lic_pkg.sv =====
// ---------------------------------------------------------------------------
// lic_pkg - shared types and constants
// Widths, status codes and the request records passed between the
// histogram front end and the bit-serial divider.
// ---------------------------------------------------------------------------
package lic_pkg;

	localparam int CHAR_W  = 8;
	localparam int CNT_W   = 16;
	localparam int SUM_W   = 32;
	localparam int IC_W    = 17;
	localparam int STAT_W  = 2;
	localparam int NBINS   = 26;
	localparam int IDX_W   = 5;
	localparam int STEP_W  = 5;
	localparam int TDATA_W = 40;

	localparam logic [CNT_W-1:0]  MAX_LEN = 16'hFFFF;
	localparam logic [CHAR_W-1:0] CHAR_A  = 8'd65;
	localparam logic [CHAR_W-1:0] CHAR_Z  = 8'd90;

	// last quotient step index (17 quotient bits)
	localparam logic [STEP_W-1:0] LAST_STEP = 5'd16;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_SHORT = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_LONG  = 2'd2;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_MUL,
		DIV_STEP,
		DIV_DONE
	} lic_div_state_t;

	// end-of-message request into the divider
	typedef struct packed {
		logic [SUM_W-1:0]  pair_sum;
		logic [CNT_W-1:0]  n;
		logic [STAT_W-1:0] status;
	} lic_div_req_t;

	// finished result
	typedef struct packed {
		logic [IC_W-1:0]   ic_value;
		logic [CNT_W-1:0]  byte_total;
		logic [STAT_W-1:0] status;
	} lic_result_t;

endpackage

// ===== sv/lic_div.sv =====
// ---------------------------------------------------------------------------
// lic_div - bit-serial Q16 divider for the index of coincidence
// Forms N*(N-1) in the multiply state, then produces floor(sum * 2^16 / (N*(N-1)))
// one quotient bit per cycle by restoring division, MSB first.
// ---------------------------------------------------------------------------
module lic_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lic_pkg::lic_div_req_t req,
	output logic                busy,
	output logic                res_valid,
	input  logic                res_ready,
	output lic_pkg::lic_result_t res
);
	import lic_pkg::*;

	`include "assert_macros.svh"

	lic_div_state_t state_q, state_nx;

	logic [SUM_W-1:0]  d_q;
	logic [SUM_W:0]    r_q;
	logic [IC_W-1:0]   quo_q;
	logic [CNT_W-1:0]  n_q;
	logic [STAT_W-1:0] stat_q;
	logic [STEP_W-1:0] cnt_q;

	logic [SUM_W:0]    trial;
	logic              qbit;
	logic [SUM_W:0]    r_keep;
	logic [CNT_W-1:0]  n_less;

	// trial subtract of one quotient step
	assign trial  = r_q - {1'b0, d_q};
	assign qbit   = (r_q >= {1'b0, d_q});
	assign r_keep = qbit ? trial : r_q;
	assign n_less = n_q - CNT_W'(1);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			DIV_IDLE: if (start) state_nx = DIV_MUL;
			DIV_MUL:  state_nx = DIV_STEP;
			DIV_STEP: if (cnt_q == LAST_STEP) state_nx = DIV_DONE;
			DIV_DONE: if (res_ready) state_nx = DIV_IDLE;
			default:  state_nx = DIV_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy               = (state_q != DIV_IDLE);
		res_valid          = (state_q == DIV_DONE);
		res.ic_value       = (stat_q == STATUS_OK) ? quo_q : '0;
		res.byte_total     = n_q;
		res.status         = stat_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == DIV_MUL)
				cnt_q <= '0;
			else if (state_q == DIV_STEP)
				cnt_q <= cnt_q + STEP_W'(1);
		end
	end

	// datapath: load, multiply, then one quotient bit per cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			DIV_IDLE: begin
				if (start) begin
					r_q    <= {1'b0, req.pair_sum};
					n_q    <= req.n;
					stat_q <= req.status;
				end
			end
			DIV_MUL: begin
				d_q   <= SUM_W'(n_q) * SUM_W'(n_less);
				quo_q <= '0;
			end
			DIV_STEP: begin
				quo_q <= {quo_q[IC_W-2:0], qbit};
				r_q   <= {r_keep[SUM_W-1:0], 1'b0};
			end
			default: ;
		endcase
	end

	`LIC_ASSERT_IMP(a_start_idle, start, state_q == DIV_IDLE, "start while divider busy")
	`LIC_ASSERT_NEXT(a_mul_step, state_q == DIV_MUL, (state_q == DIV_STEP) && (cnt_q == '0), "multiply not followed by first step")
	`LIC_ASSERT_IMP(a_ic_range, res_valid && (stat_q == STATUS_OK), res.ic_value <= 17'h10000, "index above one")

endmodule

// ===== sv/letter_index_of_coincidence_top.sv =====
// ---------------------------------------------------------------------------
// letter_index_of_coincidence_top - 26-letter index of coincidence
// Histograms capital letters of a byte stream and returns the Q16 index of
// coincidence with the byte count and a status code on each message end.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: one text byte per request on s_axis_tdata, s_axis_tlast
//   marks the final byte of a message. Bytes A to Z are binned; every byte
//   counts towards N, which saturates at 65535 (status 2 on overflow).
//   Output stream: one request per message, carrying ic_value and
//   byte_total in m_axis_tdata and the status code in m_axis_tuser.
//   Throughput: one byte per cycle inside a message. The closing byte hands
//   the sum and N to the serial divider, which forms N*(N-1) in its multiply
//   state, works out the 17 quotient bits MSB first in its step state and
//   then passes the result into the output register, which drives
//   m_axis_tvalid. s_axis_tready stays low from the closing byte until the
//   divider is idle again.
//   The output register takes the result and frees the divider; if the
//   receiver stalls, the next message streams in and waits only at its end,
//   with s_axis_tready low until the held result is taken.
//   Reset clears the histogram, counts and both handshakes at once; the
//   bins and counts clear again after every closing byte.
// ---------------------------------------------------------------------------
module letter_index_of_coincidence_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [lic_pkg::CHAR_W-1:0]   s_axis_tdata,  // [7:0] char_code
	input  logic                         s_axis_tlast,  // last
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [lic_pkg::TDATA_W-1:0]  m_axis_tdata,  // [16:0] ic_value, [32:17] byte_total
	output logic [lic_pkg::STAT_W-1:0]   m_axis_tuser   // [1:0] status
);
	import lic_pkg::*;

	`include "assert_macros.svh"

	logic [CNT_W-1:0] bins_q [NBINS];
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] pair_q;
	logic             ovf_q;

	logic              accept;
	logic              is_letter;
	logic [CHAR_W-1:0] offset;
	logic [IDX_W-1:0]  idx;
	logic              at_max;
	logic              do_bin;
	logic [CNT_W-1:0]  bin_cur;
	logic [CNT_W-1:0]  count_nx;
	logic [SUM_W-1:0]  pair_nx;
	logic              ovf_nx;

	lic_div_req_t div_req;
	lic_result_t  div_res;
	logic         div_busy;
	logic         div_valid;
	logic         div_ready;
	logic         out_load;

	logic        out_valid_q;
	lic_result_t out_q;

	// letter decode and count update
	assign accept    = s_axis_tvalid & s_axis_tready;
	assign is_letter = (s_axis_tdata >= CHAR_A) && (s_axis_tdata <= CHAR_Z);
	assign offset    = s_axis_tdata - CHAR_A;
	assign idx       = offset[IDX_W-1:0];
	assign at_max    = (count_q == MAX_LEN);
	assign do_bin    = is_letter && !at_max;
	assign bin_cur   = is_letter ? bins_q[idx] : '0;
	assign count_nx  = at_max ? count_q : count_q + CNT_W'(1);
	assign ovf_nx    = ovf_q | at_max;
	assign pair_nx   = do_bin ? pair_q + {{(SUM_W-CNT_W-1){1'b0}}, bin_cur, 1'b0} : pair_q;

	// end-of-message request
	always_comb begin
		div_req.pair_sum = pair_nx;
		div_req.n        = count_nx;
		priority if (ovf_nx)
			div_req.status = STATUS_LONG;
		else if (count_nx < CNT_W'(2))
			div_req.status = STATUS_SHORT;
		else
			div_req.status = STATUS_OK;
	end

	assign s_axis_tready = !div_busy;

	// histogram, count and pair sum; cleared on the closing byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NBINS; i++)
				bins_q[i] <= '0;
			count_q <= '0;
			pair_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				for (int i = 0; i < NBINS; i++)
					bins_q[i] <= '0;
				count_q <= '0;
				pair_q  <= '0;
				ovf_q   <= 1'b0;
			end else begin
				for (int i = 0; i < NBINS; i++)
					if (do_bin && (idx == IDX_W'(i)))
						bins_q[i] <= bin_cur + CNT_W'(1);
				count_q <= count_nx;
				pair_q  <= pair_nx;
				ovf_q   <= ovf_nx;
			end
		end
	end

	lic_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept & s_axis_tlast),
		.req       (div_req),
		.busy      (div_busy),
		.res_valid (div_valid),
		.res_ready (div_ready),
		.res       (div_res)
	);

	// output register
	assign div_ready = !out_valid_q || m_axis_tready;
	assign out_load  = div_valid && div_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= div_res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(TDATA_W-IC_W-CNT_W){1'b0}}, out_q.byte_total, out_q.ic_value};
	assign m_axis_tuser  = out_q.status;

	`LIC_ASSERT_NEXT(a_clear_after_last, accept && s_axis_tlast, (count_q == '0) && (pair_q == '0) && !ovf_q, "message state not cleared")
	`LIC_ASSERT_IMP(a_err_zero_ic, m_axis_tvalid && (m_axis_tuser != STATUS_OK), m_axis_tdata[IC_W-1:0] == '0, "error result with non-zero index")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - bench for the 26-letter index of coincidence block
// Streams text messages into the block with random gaps on the input and
// random stalls on the output. A tracker class keeps its own letter
// histogram, byte count and pair sum, works out ic_value, byte_total and
// status for every closing byte, and checks each returned result in order.
// ---------------------------------------------------------------------------
module tb;
	import lic_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_BYTES = 1300;
	localparam int CALM_AFTER = 1050;

	typedef enum {
		MIX_ANY,
		MIX_CAPS,
		MIX_FEW,
		MIX_ONE,
		MIX_PROSE
	} text_mix_t;

	// Letter histogram predictor and queue of pending results
	class coincidence_tracker;
		int unsigned bin_count[NBINS];
		int unsigned msg_bytes;
		longint unsigned pair_total;
		bit saturated;
		lic_result_t pending_ic[$];
		int unsigned faults;

		function void clear_text();
			foreach (bin_count[i])
				bin_count[i] = 0;
			msg_bytes = 0;
			pair_total = 0;
			saturated = 0;
		endfunction

		function void note_byte(logic [CHAR_W-1:0] code, logic closing);
			lic_result_t res;
			longint unsigned span;
			int unsigned slot;
			// saturated count: byte neither counted nor binned
			if (msg_bytes >= MAX_LEN) begin
				saturated = 1;
			end else begin
				msg_bytes++;
				if (code >= CHAR_A && code <= CHAR_Z) begin
					slot = code - CHAR_A;
					pair_total += 2 * bin_count[slot];
					bin_count[slot]++;
				end
			end
			if (!closing)
				return;
			res.ic_value = '0;
			res.byte_total = msg_bytes[CNT_W-1:0];
			if (saturated) begin
				res.status = STATUS_LONG;
			end else if (msg_bytes < 2) begin
				res.status = STATUS_SHORT;
			end else begin
				res.status = STATUS_OK;
				span = msg_bytes;
				span = span * (span - 1);
				res.ic_value = IC_W'((pair_total << 16) / span);
			end
			pending_ic.push_back(res);
			clear_text();
		endfunction

		function void flag(string msg);
			faults++;
			if (faults <= 10)
				$display("%t ERROR: %s", $realtime, msg);
		endfunction

		function void check_result(logic [TDATA_W-1:0] data, logic [STAT_W-1:0] user);
			lic_result_t want;
			logic [TDATA_W-1:0] want_data;
			if (pending_ic.size() == 0) begin
				flag($sformatf("result with nothing pending: tdata %h tuser %0d", data, user));
				return;
			end
			want = pending_ic.pop_front();
			want_data = '0;
			want_data[IC_W-1:0] = want.ic_value;
			want_data[IC_W+CNT_W-1:IC_W] = want.byte_total;
			if (data !== want_data || user !== want.status)
				flag($sformatf({"ic %0d/%0d bytes %0d/%0d status %0d/%0d (exp/got),",
					" tdata %h"}, want.ic_value, data[IC_W-1:0], want.byte_total,
					data[IC_W+CNT_W-1:IC_W], want.status, user, data));
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [CHAR_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic [STAT_W-1:0] m_axis_tuser;

	bit sender_gaps;
	bit receiver_stalls;
	coincidence_tracker tracker;

	letter_index_of_coincidence_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Sample both handshakes on the edge, input side first
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			tracker.note_byte(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_result(m_axis_tdata, m_axis_tuser);
	end

	// Receiver: stall bursts, with m_axis_tready raised again between them
	initial begin
		forever begin
			@(posedge clk);
			if (receiver_stalls && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog on cycles with no request moving either way
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// One byte request, with an optional gap of junk data ahead of it
	task automatic put_byte(input logic [CHAR_W-1:0] code, input logic closing);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= CHAR_W'($urandom);
			s_axis_tlast <= 1'($urandom);
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= code;
		s_axis_tlast <= closing;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_text(input logic [CHAR_W-1:0] text[$]);
		foreach (text[i])
			put_byte(text[i], i == text.size() - 1);
	endtask

	function automatic logic [CHAR_W-1:0] pick_char(text_mix_t mix, logic [CHAR_W-1:0] solo);
		case (mix)
			MIX_CAPS: return CHAR_A + CHAR_W'($urandom_range(0, NBINS - 1));
			MIX_FEW:  return CHAR_A + CHAR_W'($urandom_range(0, 3));
			MIX_ONE:  return solo;
			MIX_PROSE: begin
				case ($urandom_range(0, 7))
					0: return 8'h20;
					1: return CHAR_W'($urandom);
					default: return CHAR_A + CHAR_W'($urandom_range(0, NBINS - 1));
				endcase
			end
			default:  return CHAR_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [CHAR_W-1:0] text[$];
		logic [CHAR_W-1:0] solo;
		text_mix_t mix;
		int unsigned len;
		int unsigned sent;

		tracker = new();
		tracker.clear_text();
		sender_gaps = 1;
		receiver_stalls = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short messages: single letter, single non-letter
		send_text({CHAR_A});
		send_text({8'hFF});
		// Two equal letters give the top value, two different give zero
		send_text({CHAR_A, CHAR_A});
		send_text({CHAR_A, CHAR_Z});
		// Bytes just outside the letter range are counted but not binned
		send_text({8'h40, 8'h5B, 8'h00, 8'hFF});
		send_text({CHAR_Z, CHAR_Z, CHAR_Z, 8'h40});

		// Random messages, quiet handshakes towards the end
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			case ($urandom_range(0, 9))
				0: len = 1;
				1: len = 2;
				8: len = $urandom_range(21, 60);
				9: len = $urandom_range(61, 200);
				default: len = $urandom_range(3, 20);
			endcase
			mix = text_mix_t'($urandom_range(0, 4));
			solo = pick_char(MIX_CAPS, CHAR_A);
			sender_gaps = sent < CALM_AFTER && $urandom_range(0, 2) != 0;
			receiver_stalls = sent < CALM_AFTER && $urandom_range(0, 2) != 0;
			text = {};
			repeat (len) text.push_back(pick_char(mix, solo));
			send_text(text);
			sent += len;
		end
		s_axis_tvalid <= 1'b0;

		// Drain, then let the divider settle
		while (tracker.pending_ic.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.faults == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lic_pkg.sv
sv/lic_div.sv
sv/letter_index_of_coincidence_top.sv
sim/tb.sv
